>>> src/gscc_pkg.sv
// ----------------------------------------------------------------------------
// gscc_pkg
// Shared widths, register indexes and the controller/datapath interface types
// of the grid segment collision checker.
// ----------------------------------------------------------------------------
`default_nettype none

package gscc_pkg;

    // field and arithmetic widths
    localparam int COORD_W   = 32;                 // Q16.16 coordinates
    localparam int SIZE_W    = 31;                 // cell size register
    localparam int DIM_W     = 9;                  // cells_wide / cells_high
    localparam int CFG_W     = 32;                 // config write data
    localparam int CFG_IDX_W = 3;
    localparam int MAG_W     = COORD_W + 1;        // |end - start|
    localparam int DIST_W    = 34;                 // floor(sqrt(dx^2+dy^2))
    localparam int MUL_W     = 34;                 // shared multiplier operands
    localparam int SQ_W      = 2 * MAG_W;          // one square
    localparam int SQRT_IN_W = 2 * DIST_W;         // padded radicand
    localparam int SQRT_REM_W = DIST_W + 4;
    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = DIST_W;
    localparam int UNIT_FRAC = 30;
    localparam int UNIT_W    = UNIT_FRAC + 1;      // unit vector magnitude
    localparam int STRIDE_W  = SIZE_W + 1;         // 2 * cell size
    localparam int STEP_W    = STRIDE_W + UNIT_W;  // stride * unit
    localparam int ACC_W     = 64;                 // n * stride * unit
    localparam int OFF_W     = ACC_W - UNIT_FRAC;  // offset from start
    localparam int REL_W     = 42;                 // point - origin
    localparam int WD_W      = DIM_W + SIZE_W;     // grid extent in world units
    localparam int Q_W       = DIM_W;              // cell index quotient
    localparam int DSH_W     = SIZE_W + Q_W - 1;
    localparam int REM_W     = REL_W - 1;

    // iteration counts
    localparam int SQRT_ITER = DIST_W;
    localparam int DIV_ITER  = DIV_NUM_W;
    localparam int MAP_ITER  = Q_W;
    localparam int CNT_W     = 6;

    // input kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_WIDE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_HIGH = 3'd4;

    // register reset values
    localparam logic [SIZE_W-1:0] CELL_SIZE_RST = 31'd3277;
    localparam logic [DIM_W-1:0]  CELLS_RST     = 9'd256;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_AX,
        MUL_AY,
        MUL_SX,
        MUL_SY
    } mul_sel_t;

    typedef enum logic [1:0] {
        DIV_STEPS,
        DIV_UX,
        DIV_UY
    } div_sel_t;

    typedef struct packed {
        logic     clr_step;
        logic     wr_cell;
        logic     load;
        mul_sel_t mul_sel;
        logic     sqrt_start;
        logic     sqrt_step;
        logic     div_start;
        div_sel_t div_sel;
        logic     div_step;
        logic     div_store;
        logic     pt_end;
        logic     pt_sample;
        logic     map_step;
        logic     rd_issue;
        logic     loop_init;
        logic     loop_next;
    } gscc_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic short_seg;
        logic hit;
        logic loop_done;
    } gscc_sts_t;

endpackage

`default_nettype wire

>>> src/gscc_ctrl.sv
// ----------------------------------------------------------------------------
// gscc_ctrl
// Sequencer: clears the grid after reset, takes input beats, steps the
// datapath through square root, divisions and the point walk, and holds the
// result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module gscc_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               kind,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    collides,
    output gscc_pkg::gscc_cmd_t     cmd,
    input  wire gscc_pkg::gscc_sts_t sts
);
    import gscc_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL_AX,
        S_MUL_AY,
        S_SQRT_INIT,
        S_SQRT,
        S_END_LOAD,
        S_MAP,
        S_RD,
        S_CHK,
        S_DIV_INIT,
        S_DIV,
        S_DIV_STORE,
        S_MUL_SX,
        S_MUL_SY,
        S_LOOP_INIT,
        S_LOOP_TEST,
        S_PT_LOAD,
        S_PT_NEXT,
        S_DONE
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    div_sel_t         div_sel_reg;
    logic             is_end_reg;
    logic             result_reg;
    logic             out_valid_reg;
    logic             collides_reg;
    logic             accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign collides  = collides_reg;

    // command decode
    always_comb
    begin
        cmd            = '0;
        cmd.mul_sel    = MUL_NONE;
        cmd.div_sel    = div_sel_reg;
        unique case (state_reg)
            S_CLEAR:     cmd.clr_step   = 1'b1;
            S_IDLE:
            begin
                cmd.wr_cell = accept && (kind == KIND_WRITE);
                cmd.load    = accept && (kind == KIND_QUERY);
            end
            S_MUL_AX:    cmd.mul_sel    = MUL_AX;
            S_MUL_AY:    cmd.mul_sel    = MUL_AY;
            S_SQRT_INIT: cmd.sqrt_start = 1'b1;
            S_SQRT:      cmd.sqrt_step  = 1'b1;
            S_END_LOAD:  cmd.pt_end     = 1'b1;
            S_MAP:       cmd.map_step   = 1'b1;
            S_RD:        cmd.rd_issue   = 1'b1;
            S_DIV_INIT:  cmd.div_start  = 1'b1;
            S_DIV:       cmd.div_step   = 1'b1;
            S_DIV_STORE: cmd.div_store  = 1'b1;
            S_MUL_SX:    cmd.mul_sel    = MUL_SX;
            S_MUL_SY:    cmd.mul_sel    = MUL_SY;
            S_LOOP_INIT: cmd.loop_init  = 1'b1;
            S_PT_LOAD:   cmd.pt_sample  = 1'b1;
            S_PT_NEXT:   cmd.loop_next  = 1'b1;
            S_CHK, S_LOOP_TEST, S_DONE: ;
            default: ;
        endcase
    end

    // state, counters and result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            div_sel_reg   <= DIV_STEPS;
            is_end_reg    <= 1'b0;
            result_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            collides_reg  <= 1'b0;
        end
        else
        begin
            // S_DONE drives the valid flag itself
            if (out_valid_reg && out_ready && (state_reg != S_DONE))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_CLEAR:
                    if (sts.clr_last)
                        state_reg <= S_IDLE;
                S_IDLE:
                    if (accept && (kind == KIND_QUERY))
                        state_reg <= S_MUL_AX;
                S_MUL_AX:    state_reg <= S_MUL_AY;
                S_MUL_AY:    state_reg <= S_SQRT_INIT;
                S_SQRT_INIT:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(SQRT_ITER - 1))
                        state_reg <= S_END_LOAD;
                end
                S_END_LOAD:
                begin
                    is_end_reg <= 1'b1;
                    cnt_reg    <= '0;
                    state_reg  <= S_MAP;
                end
                S_MAP:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(MAP_ITER - 1))
                        state_reg <= S_RD;
                end
                S_RD:        state_reg <= S_CHK;
                S_CHK:
                    priority if (sts.hit)
                    begin
                        result_reg <= 1'b1;
                        state_reg  <= S_DONE;
                    end
                    else if (is_end_reg && sts.short_seg)
                    begin
                        result_reg <= 1'b0;
                        state_reg  <= S_DONE;
                    end
                    else if (is_end_reg)
                    begin
                        div_sel_reg <= DIV_STEPS;
                        state_reg   <= S_DIV_INIT;
                    end
                    else
                        state_reg <= S_PT_NEXT;
                S_DIV_INIT:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(DIV_ITER - 1))
                        state_reg <= S_DIV_STORE;
                end
                S_DIV_STORE:
                    unique case (div_sel_reg)
                        DIV_STEPS:
                        begin
                            div_sel_reg <= DIV_UX;
                            state_reg   <= S_DIV_INIT;
                        end
                        DIV_UX:
                        begin
                            div_sel_reg <= DIV_UY;
                            state_reg   <= S_DIV_INIT;
                        end
                        default:     state_reg <= S_MUL_SX;
                    endcase
                S_MUL_SX:    state_reg <= S_MUL_SY;
                S_MUL_SY:    state_reg <= S_LOOP_INIT;
                S_LOOP_INIT: state_reg <= S_LOOP_TEST;
                S_LOOP_TEST:
                    if (sts.loop_done)
                    begin
                        result_reg <= 1'b0;
                        state_reg  <= S_DONE;
                    end
                    else
                        state_reg <= S_PT_LOAD;
                S_PT_LOAD:
                begin
                    is_end_reg <= 1'b0;
                    cnt_reg    <= '0;
                    state_reg  <= S_MAP;
                end
                S_PT_NEXT:   state_reg <= S_LOOP_TEST;
                S_DONE:
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        collides_reg  <= result_reg;
                        state_reg     <= S_IDLE;
                    end
                default:     state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> src/gscc_dp.sv
// ----------------------------------------------------------------------------
// gscc_dp
// Datapath: configuration registers, cost grid memory, shared multiplier,
// bit-serial square root, shared restoring divider and the point-to-cell
// mapper.
// ----------------------------------------------------------------------------
`default_nettype none

module gscc_dp #(
    parameter int GRID_COLS = 256,
    parameter int GRID_ROWS = 256
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [gscc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [gscc_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic signed [gscc_pkg::COORD_W-1:0] start_x,
    input  wire logic signed [gscc_pkg::COORD_W-1:0] start_y,
    input  wire logic signed [gscc_pkg::COORD_W-1:0] end_x,
    input  wire logic signed [gscc_pkg::COORD_W-1:0] end_y,
    input  wire logic [7:0]                        cell_col,
    input  wire logic [7:0]                        cell_row,
    input  wire logic [7:0]                        cell_cost,
    input  wire gscc_pkg::gscc_cmd_t               cmd,
    output gscc_pkg::gscc_sts_t                    sts
);
    import gscc_pkg::*;

    localparam int CW = $clog2(GRID_COLS);
    localparam int RW = $clog2(GRID_ROWS);
    localparam int AW = CW + RW;

    // configuration
    logic [SIZE_W-1:0]         cell_size_reg;
    logic signed [COORD_W-1:0] origin_x_reg;
    logic signed [COORD_W-1:0] origin_y_reg;
    logic [DIM_W-1:0]          cells_wide_reg;
    logic [DIM_W-1:0]          cells_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_size_reg  <= CELL_SIZE_RST;
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            cells_wide_reg <= CELLS_RST;
            cells_high_reg <= CELLS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CELL_SIZE:  cell_size_reg  <= cfg_data[SIZE_W-1:0];
                CFG_ORIGIN_X:   origin_x_reg   <= cfg_data;
                CFG_ORIGIN_Y:   origin_y_reg   <= cfg_data;
                CFG_CELLS_WIDE: cells_wide_reg <= cfg_data[DIM_W-1:0];
                CFG_CELLS_HIGH: cells_high_reg <= cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // derived sizes: zero cell size acts as one, grid extent clamped
    logic [SIZE_W-1:0]   eff_d;
    logic [STRIDE_W-1:0] stride;
    logic [DIM_W-1:0]    w_eff;
    logic [DIM_W-1:0]    h_eff;
    logic [WD_W-1:0]     wd_reg;
    logic [WD_W-1:0]     hd_reg;

    assign eff_d  = (cell_size_reg == '0) ? SIZE_W'(1) : cell_size_reg;
    assign stride = {eff_d, 1'b0};
    assign w_eff  = (int'(cells_wide_reg) > GRID_COLS) ? DIM_W'(GRID_COLS) : cells_wide_reg;
    assign h_eff  = (int'(cells_high_reg) > GRID_ROWS) ? DIM_W'(GRID_ROWS) : cells_high_reg;

    always_ff @(posedge clk)
    begin
        wd_reg <= WD_W'(w_eff) * WD_W'(eff_d);
        hd_reg <= WD_W'(h_eff) * WD_W'(eff_d);
    end

    // query latch: start, end, direction signs and magnitudes
    logic signed [COORD_W-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic                      negx_reg, negy_reg;
    logic [MAG_W-1:0]          ax_reg, ay_reg;
    logic signed [MAG_W-1:0]   dx, dy;

    assign dx = MAG_W'(end_x) - MAG_W'(start_x);
    assign dy = MAG_W'(end_y) - MAG_W'(start_y);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sx_reg   <= start_x;
            sy_reg   <= start_y;
            ex_reg   <= end_x;
            ey_reg   <= end_y;
            negx_reg <= dx[MAG_W-1];
            negy_reg <= dy[MAG_W-1];
            ax_reg   <= dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
            ay_reg   <= dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
        end
    end

    // shared multiplier
    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [2*MUL_W-1:0] prod;
    logic [SQ_W-1:0]    sqx_reg, sqy_reg;
    logic [STEP_W-1:0]  stepx_reg, stepy_reg;
    logic [UNIT_W-1:0]  uxm_reg, uym_reg;

    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_AX:
            begin
                mul_a = MUL_W'(ax_reg);
                mul_b = MUL_W'(ax_reg);
            end
            MUL_AY:
            begin
                mul_a = MUL_W'(ay_reg);
                mul_b = MUL_W'(ay_reg);
            end
            MUL_SX:
            begin
                mul_a = MUL_W'(stride);
                mul_b = MUL_W'(uxm_reg);
            end
            MUL_SY:
            begin
                mul_a = MUL_W'(stride);
                mul_b = MUL_W'(uym_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        unique case (cmd.mul_sel)
            MUL_AX:  sqx_reg   <= prod[SQ_W-1:0];
            MUL_AY:  sqy_reg   <= prod[SQ_W-1:0];
            MUL_SX:  stepx_reg <= prod[STEP_W-1:0];
            MUL_SY:  stepy_reg <= prod[STEP_W-1:0];
            default: ;
        endcase
    end

    // square root, one result bit a cycle
    logic [SQRT_IN_W-1:0]  sq_in_reg;
    logic [SQRT_REM_W-1:0] sq_rem_reg;
    logic [DIST_W-1:0]     dist_reg;
    logic [SQRT_REM_W-1:0] sq_rem2, sq_trial;
    logic                  sq_ge;

    assign sq_rem2  = {sq_rem_reg[SQRT_REM_W-3:0], sq_in_reg[SQRT_IN_W-1 -: 2]};
    assign sq_trial = SQRT_REM_W'({dist_reg, 2'b01});
    assign sq_ge    = (sq_rem2 >= sq_trial);

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_start)
        begin
            sq_in_reg  <= SQRT_IN_W'(sqx_reg) + SQRT_IN_W'(sqy_reg);
            sq_rem_reg <= '0;
            dist_reg   <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            sq_in_reg  <= sq_in_reg << 2;
            sq_rem_reg <= sq_ge ? (sq_rem2 - sq_trial) : sq_rem2;
            dist_reg   <= {dist_reg[DIST_W-2:0], sq_ge};
        end
    end

    // restoring divider, one quotient bit a cycle
    logic [DIV_NUM_W-1:0] dq_reg;
    logic [DIV_DEN_W-1:0] dr_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W:0]   dr2;
    logic                 d_ge;
    logic [DIST_W-1:0]    steps_reg;

    assign dr2  = {dr_reg, dq_reg[DIV_NUM_W-1]};
    assign d_ge = (dr2 >= {1'b0, den_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dr_reg <= '0;
            unique case (cmd.div_sel)
                DIV_STEPS:
                begin
                    dq_reg  <= DIV_NUM_W'(dist_reg);
                    den_reg <= DIV_DEN_W'(stride);
                end
                DIV_UX:
                begin
                    dq_reg  <= DIV_NUM_W'({ax_reg, UNIT_FRAC'(0)});
                    den_reg <= dist_reg;
                end
                default:
                begin
                    dq_reg  <= DIV_NUM_W'({ay_reg, UNIT_FRAC'(0)});
                    den_reg <= dist_reg;
                end
            endcase
        end
        else if (cmd.div_step)
        begin
            dq_reg <= {dq_reg[DIV_NUM_W-2:0], d_ge};
            dr_reg <= d_ge ? DIV_DEN_W'(dr2 - {1'b0, den_reg}) : DIV_DEN_W'(dr2);
        end
        else if (cmd.div_store)
        begin
            unique case (cmd.div_sel)
                DIV_STEPS: steps_reg <= dq_reg[DIST_W-1:0];
                DIV_UX:    uxm_reg   <= dq_reg[UNIT_W-1:0];
                default:   uym_reg   <= dq_reg[UNIT_W-1:0];
            endcase
        end
    end

    // sample walk: n and n * stride * unit
    logic [DIST_W-1:0] n_reg;
    logic [ACC_W-1:0]  accx_reg, accy_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.loop_init)
        begin
            n_reg    <= DIST_W'(1);
            accx_reg <= ACC_W'(stepx_reg);
            accy_reg <= ACC_W'(stepy_reg);
        end
        else if (cmd.loop_next)
        begin
            n_reg    <= n_reg + 1'b1;
            accx_reg <= accx_reg + ACC_W'(stepx_reg);
            accy_reg <= accy_reg + ACC_W'(stepy_reg);
        end
    end

    // point position relative to the grid corner
    logic [REL_W-1:0] offx, offy, ptx, pty, relx, rely;

    assign offx = REL_W'(accx_reg[ACC_W-1 -: OFF_W]);
    assign offy = REL_W'(accy_reg[ACC_W-1 -: OFF_W]);

    always_comb
    begin
        if (cmd.pt_end)
        begin
            ptx = REL_W'(ex_reg);
            pty = REL_W'(ey_reg);
        end
        else
        begin
            ptx = REL_W'(sx_reg) + (negx_reg ? -offx : offx);
            pty = REL_W'(sy_reg) + (negy_reg ? -offy : offy);
        end
    end

    assign relx = ptx - REL_W'(origin_x_reg);
    assign rely = pty - REL_W'(origin_y_reg);

    // cell mapping: bounds check plus a short restoring division
    logic [REL_W-1:0] relx_reg, rely_reg;
    logic [REM_W-1:0] remx_reg, remy_reg;
    logic [DSH_W-1:0] dsh_reg;
    logic [Q_W-1:0]   qx_reg, qy_reg;
    logic             gx, gy, oobx, ooby;

    assign gx = (remx_reg >= REM_W'(dsh_reg));
    assign gy = (remy_reg >= REM_W'(dsh_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.pt_end || cmd.pt_sample)
        begin
            relx_reg <= relx;
            rely_reg <= rely;
            remx_reg <= relx[REM_W-1:0];
            remy_reg <= rely[REM_W-1:0];
            dsh_reg  <= {eff_d, (Q_W-1)'(0)};
            qx_reg   <= '0;
            qy_reg   <= '0;
        end
        else if (cmd.map_step)
        begin
            remx_reg <= gx ? (remx_reg - REM_W'(dsh_reg)) : remx_reg;
            remy_reg <= gy ? (remy_reg - REM_W'(dsh_reg)) : remy_reg;
            qx_reg   <= {qx_reg[Q_W-2:0], gx};
            qy_reg   <= {qy_reg[Q_W-2:0], gy};
            dsh_reg  <= dsh_reg >> 1;
        end
    end

    assign oobx = relx_reg[REL_W-1] || (relx_reg >= REL_W'(wd_reg));
    assign ooby = rely_reg[REL_W-1] || (rely_reg >= REL_W'(hd_reg));

    // cost grid memory with clearing sweep
    logic [7:0]    grid_mem [2**AW];
    logic [AW-1:0] clr_addr_reg;
    logic [7:0]    rd_data_reg;
    logic          wr_in_range;

    assign wr_in_range = (int'(cell_col) < GRID_COLS) && (int'(cell_row) < GRID_ROWS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_addr_reg <= '0;
        else if (cmd.clr_step)
            clr_addr_reg <= clr_addr_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
            grid_mem[clr_addr_reg] <= 8'd0;
        else if (cmd.wr_cell && wr_in_range)
            grid_mem[{RW'(cell_row), CW'(cell_col)}] <= cell_cost;
        if (cmd.rd_issue)
            rd_data_reg <= grid_mem[{RW'(qy_reg), CW'(qx_reg)}];
    end

    // status
    assign sts.clr_last  = &clr_addr_reg;
    assign sts.short_seg = (dist_reg < DIST_W'(stride));
    assign sts.hit       = oobx || ooby || (rd_data_reg != 8'd0);
    assign sts.loop_done = (n_reg >= steps_reg);

endmodule

`default_nettype wire

>>> src/grid_segment_collision_check.sv
// ----------------------------------------------------------------------------
// grid_segment_collision_check
// Occupancy cost grid with a segment collision query. Write beats fill one
// cell; query beats return whether the segment hits an occupied or
// out-of-bounds cell.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   kind, start/end x/y, cell fields
//   out      output     out_valid / out_ready collides
//   cfg      input      cfg_we                cfg_index, cfg_data
//
// After reset a clearing sweep zeroes the grid, one cell a cycle; in_ready
// is low then. A write beat is written to the grid in the cycle it is taken.
// A query runs to the end-point test (34-step square root, 9-step cell map),
// then, unless the end point settles the result, three divisions on the shared
// divider, then for each sample point a loop test, a cell map and one grid
// memory read.
// A finished result waits in the output register while the next beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_segment_collision_check #(
    parameter int GRID_COLS = 256,
    parameter int GRID_ROWS = 256
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              kind,
    input  wire logic signed [gscc_pkg::COORD_W-1:0] start_x,
    input  wire logic signed [gscc_pkg::COORD_W-1:0] start_y,
    input  wire logic signed [gscc_pkg::COORD_W-1:0] end_x,
    input  wire logic signed [gscc_pkg::COORD_W-1:0] end_y,
    input  wire logic [7:0]                        cell_col,
    input  wire logic [7:0]                        cell_row,
    input  wire logic [7:0]                        cell_cost,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   collides,
    input  wire logic                              cfg_we,
    input  wire logic [gscc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [gscc_pkg::CFG_W-1:0]        cfg_data
);
    import gscc_pkg::*;

    gscc_cmd_t cmd;
    gscc_sts_t sts;

    // sequencer
    gscc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .collides  (collides),
        .cmd       (cmd),
        .sts       (sts)
    );

    // arithmetic and grid storage
    gscc_dp #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .cell_col  (cell_col),
        .cell_row  (cell_row),
        .cell_cost (cell_cost),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

>>> verif/tb_grid_segment_collision_check.sv
// ----------------------------------------------------------------------------
// tb_grid_segment_collision_check
// Self-checking bench for the grid segment collision checker. A table of
// directed beats runs first, then random grid writes and segment queries over
// several register settings and idle patterns. Every query result is compared
// with a value from the table or from a bit-exact software copy of the grid and of the query arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_grid_segment_collision_check;
    import gscc_pkg::*;

    localparam int NCOLS = 256;
    localparam int NROWS = 256;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd5;   // unmapped index

    typedef struct {
        logic        kind;
        logic [31:0] sx, sy, ex, ey;
        logic [7:0]  col, row, cost;
    } beat_t;

    typedef struct {
        beat_t b;
        bit    typed;      // expected value given in the table
        bit    want;
    } dir_row_t;

    typedef struct {
        logic [31:0] size, ox, oy, wide, high;
        int          beats;
        bit          tx_idle, rx_stall, hold;
    } phase_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic kind = 1'b0;
    logic signed [COORD_W-1:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
    logic [7:0] cell_col = '0, cell_row = '0, cell_cost = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic collides;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    // shadow state
    logic [7:0]  grid_copy [NCOLS*NROWS];
    longint unsigned sh_size;
    longint      sh_ox, sh_oy;
    longint unsigned sh_wide, sh_high;
    bit          hits_due [$];
    int          errors = 0;
    bit          tx_idle = 0, rx_stall = 0;
    int          idle_pct = 73;     // idle / stall odds out of a hundred
    int          hold_req = 0;
    int          hold_left = 0;

    grid_segment_collision_check dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .start_x(start_x), .start_y(start_y),
        .end_x(end_x), .end_y(end_y),
        .cell_col(cell_col), .cell_row(cell_row), .cell_cost(cell_cost),
        .out_valid(out_valid), .out_ready(out_ready), .collides(collides),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #200_000_000;
        $display("grid_segment_collision_check test failed");
        $finish;
    end

    // ---------------- prediction ----------------

    function automatic longint unsigned cell_div();
        return (sh_size == 0) ? 1 : sh_size;
    endfunction

    function automatic longint floor_quot(longint num, longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0)
            q = q - 1;
        return q;
    endfunction

    // point lands out of bounds or on a costly cell
    function automatic bit point_blocked(longint wx, longint wy);
        longint d, cx, cy, w, h;
        d  = longint'(cell_div());
        cx = floor_quot(wx - sh_ox, d);
        cy = floor_quot(wy - sh_oy, d);
        w  = (sh_wide < NCOLS) ? longint'(sh_wide) : NCOLS;
        h  = (sh_high < NROWS) ? longint'(sh_high) : NROWS;
        if (cx < 0 || cy < 0 || cx >= w || cy >= h)
            return 1'b1;
        return grid_copy[cy * NCOLS + cx] != 0;
    endfunction

    function automatic longint step_offset(longint unsigned along,
                                           longint unsigned umag, bit neg);
        longint unsigned p;
        longint m;
        p = (along * umag) >> UNIT_FRAC;
        m = longint'(p);
        return neg ? -m : m;
    endfunction

    function automatic bit segment_blocked(longint sx, longint sy, longint ex, longint ey);
        longint dx, dy, px, py;
        longint unsigned ax, ay, stride, seg_len, steps, uxm, uym, n;
        logic [127:0] sq, t;
        dx = ex - sx;
        dy = ey - sy;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        stride = 2 * cell_div();
        sq = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
        seg_len = 0;
        for (int b = 35; b >= 0; b--)
        begin
            t = 128'(seg_len | (64'd1 << b));
            if (t * t <= sq)
                seg_len = t[63:0];
        end
        if (point_blocked(ex, ey))
            return 1'b1;
        if (seg_len < stride)
            return 1'b0;
        steps = seg_len / stride;
        uxm = (ax << UNIT_FRAC) / seg_len;
        uym = (ay << UNIT_FRAC) / seg_len;
        for (n = 1; n < steps; n++)
        begin
            px = sx + step_offset(n * stride, uxm, dx < 0);
            py = sy + step_offset(n * stride, uym, dy < 0);
            if (point_blocked(px, py))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void shadow_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
        case (idx)
            CFG_CELL_SIZE:  sh_size = v[30:0];
            CFG_ORIGIN_X:   sh_ox = longint'(signed'(v));
            CFG_ORIGIN_Y:   sh_oy = longint'(signed'(v));
            CFG_CELLS_WIDE: sh_wide = v[8:0];
            CFG_CELLS_HIGH: sh_high = v[8:0];
            default: ;
        endcase
    endfunction

    // ---------------- checking ----------------

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("ERROR @%0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // out_ready only moves at rising edges, so the falling edge sees the beat
    always @(negedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (hits_due.size() == 0)
                report_mismatch("unexpected result beat, collides", collides, -1);
            else if (collides !== hits_due[0])
                report_mismatch("collides", collides, hits_due.pop_front());
            else
                void'(hits_due.pop_front());
        end
    end

    // receiver: random stalls plus an occasional long hold-off
    always @(posedge clk)
    begin
        if (hold_req > 0 && hold_left == 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= rx_stall ? ($urandom_range(99) >= idle_pct) : 1'b1;
    end

    // ---------------- stimulus ----------------

    task automatic write_regs(phase_t p, bit spare);
        logic [CFG_IDX_W-1:0] idx [6];
        logic [31:0] val [6];
        idx = '{CFG_CELL_SIZE, CFG_ORIGIN_X, CFG_ORIGIN_Y, CFG_CELLS_WIDE,
                CFG_CELLS_HIGH, CFG_SPARE};
        val = '{p.size, p.ox, p.oy, p.wide, p.high, $urandom()};
        for (int i = 0; i < (spare ? 6 : 5); i++)
        begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            shadow_reg(idx[i], val[i]);
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // offer one beat, wait for the handshake, then record what it must produce
    task automatic send_beat(beat_t b, bit typed, bit want);
        bit fire;
        if (tx_idle)
        begin
            while ($urandom_range(99) < idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        kind <= b.kind;
        start_x <= b.sx;
        start_y <= b.sy;
        end_x <= b.ex;
        end_y <= b.ey;
        cell_col <= b.col;
        cell_row <= b.row;
        cell_cost <= b.cost;
        do
        begin
            @(negedge clk);
            fire = in_ready;
            @(posedge clk);
        end while (!fire);
        if (b.kind == KIND_WRITE)
            grid_copy[b.row * NCOLS + b.col] = b.cost;
        else if (typed)
            hits_due.push_back(want);
        else
            hits_due.push_back(segment_blocked(longint'(signed'(b.sx)),
                longint'(signed'(b.sy)), longint'(signed'(b.ex)),
                longint'(signed'(b.ey))));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (hits_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // world coordinate near a cell in use on one axis
    function automatic logic [31:0] world_near(longint org, longint unsigned cells);
        longint c, unit;
        unit = longint'(cell_div());
        if (cells > NCOLS)
            cells = NCOLS;
        c = (cells == 0) ? 0 : $urandom_range(int'(cells) - 1);
        if ($urandom_range(9) == 0)
            c = $urandom_range(1) ? -1 : longint'(cells);
        return 32'(org + c * unit + longint'($urandom() % unit));
    endfunction

    function automatic beat_t random_beat();
        beat_t b;
        longint unsigned w, h, dcx, dcy;
        int pick;
        w = (sh_wide > NCOLS) ? NCOLS : sh_wide;
        h = (sh_high > NROWS) ? NROWS : sh_high;
        b.sx = $urandom(); b.sy = $urandom(); b.ex = $urandom(); b.ey = $urandom();
        b.col = 8'($urandom()); b.row = 8'($urandom()); b.cost = 8'($urandom());
        b.kind = ($urandom_range(99) < 40) ? KIND_WRITE : KIND_QUERY;
        if (b.kind == KIND_WRITE)
        begin
            if ($urandom_range(9) != 0)
            begin
                b.col = (w == 0) ? 8'd0 : 8'($urandom_range(int'(w) - 1));
                b.row = (h == 0) ? 8'd0 : 8'($urandom_range(int'(h) - 1));
                if ($urandom_range(99) < 65)
                    b.cost = 8'd0;
            end
            return b;
        end
        pick = $urandom_range(99);
        if (pick < 85)
        begin
            b.ex = world_near(sh_ox, w);
            b.ey = world_near(sh_oy, h);
        end
        if (pick < 70)
        begin
            // short-to-medium segment ending near the grid
            dcx = $urandom_range(40);
            dcy = $urandom_range(40);
            b.sx = 32'(longint'(signed'(b.ex)) +
                   ($urandom_range(1) ? 1 : -1) * longint'(dcx * cell_div()) +
                   longint'($urandom() % cell_div()));
            b.sy = 32'(longint'(signed'(b.ey)) +
                   ($urandom_range(1) ? 1 : -1) * longint'(dcy * cell_div()));
        end
        return b;
    endfunction

    initial
    begin
        dir_row_t dir_tab [];
        phase_t   phases [];
        phase_t   p;

        for (int i = 0; i < NCOLS*NROWS; i++)
            grid_copy[i] = 8'd0;
        sh_size = CELL_SIZE_RST;
        sh_ox = 0;
        sh_oy = 0;
        sh_wide = CELLS_RST;
        sh_high = CELLS_RST;

        // directed beats at reset settings (cell 3277, 256 x 256, origin 0)
        dir_tab = '{
            '{'{KIND_QUERY, 0, 0, 0, 0, 0, 0, 0}, 1, 0},                  // zero length
            '{'{KIND_QUERY, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0}, 1, 1},      // end left of grid
            '{'{KIND_QUERY, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0}, 1, 1},
            '{'{KIND_QUERY, 0, 0, 32'h8000_0000, 32'h8000_0000, 0, 0, 0}, 1, 1},
            '{'{KIND_QUERY, 32'h8000_0000, 32'h8000_0000, 10, 10, 0, 0, 0}, 0, 0},
            '{'{KIND_QUERY, 32'h7FFF_FFFF, 0, 10, 10, 0, 0, 0}, 0, 0},
            '{'{KIND_WRITE, 0, 0, 0, 0, 8'd255, 8'd255, 8'd255}, 0, 0},
            '{'{KIND_QUERY, 0, 0, 835636, 835636, 0, 0, 0}, 1, 1},        // costly corner
            '{'{KIND_WRITE, 0, 0, 0, 0, 8'd0, 8'd0, 8'd1}, 0, 0},
            '{'{KIND_QUERY, 5, 5, 0, 0, 0, 0, 0}, 1, 1},
            '{'{KIND_WRITE, 0, 0, 0, 0, 8'd0, 8'd0, 8'd0}, 0, 0},
            '{'{KIND_QUERY, 5, 5, 0, 0, 0, 0, 0}, 1, 0},
            '{'{KIND_QUERY, 1, 1, 6000, 1, 0, 0, 0}, 1, 0},               // shorter than stride
            '{'{KIND_QUERY, 1, 1, 6555, 1, 0, 0, 0}, 0, 0},               // exactly one stride
            '{'{KIND_WRITE, 0, 0, 0, 0, 8'd100, 8'd100, 8'd9}, 0, 0},
            '{'{KIND_QUERY, 0, 0, 700000, 700000, 0, 0, 0}, 0, 0},        // crosses 100,100
            '{'{KIND_QUERY, 700000, 700000, 10, 10, 0, 0, 0}, 0, 0},      // negative direction
            '{'{KIND_QUERY, 330000, 10, 330000, 800000, 0, 0, 0}, 0, 0},  // vertical
            '{'{KIND_QUERY, 10, 329000, 800000, 329000, 0, 0, 0}, 0, 0},  // horizontal
            '{'{KIND_WRITE, 0, 0, 0, 0, 8'd100, 8'd100, 8'd0}, 0, 0},
            '{'{KIND_QUERY, 0, 0, 700000, 700000, 0, 0, 0}, 1, 0}
        };

        phases = '{
            '{32'd3277, 32'd0, 32'd0, 32'd256, 32'd256, 200, 0, 0, 0},
            '{32'd1, -32'sd100, 32'd50, 32'd16, 32'd16, 200, 1, 0, 0},
            '{32'd0, 32'd7, -32'sd7, 32'd300, 32'd5, 200, 0, 1, 0},
            '{32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'd1, 32'd1, 150, 1, 1, 0},
            '{32'd65536, -32'sd327680, -32'sd196608, 32'd40, 32'd30, 200, 0, 0, 1},
            '{32'd3277, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd256, 80, 0, 0, 0},
            '{32'd20000, 32'h1234_5678, -32'sd262144, 32'h1FF, 32'd256, 200, 1, 1, 0}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i])
            send_beat(dir_tab[i].b, dir_tab[i].typed, dir_tab[i].want);
        drain();

        foreach (phases[k])
        begin
            p = phases[k];
            write_regs(p, k == 1);
            tx_idle = p.tx_idle;
            rx_stall = p.rx_stall;
            // both sides idling together use the lighter odds
            idle_pct = (p.tx_idle && p.rx_stall) ? 24 : 73;
            if (p.hold)
                hold_req = 3000;
            for (int i = 0; i < p.beats; i++)
            begin
                send_beat(random_beat(), 0, 0);
                // sender pause until every result is back
                if (p.hold && i == 100)
                    drain();
            end
            drain();
        end

        // back to reset-like settings for a last mixed run, no idling
        p = phases[0];
        tx_idle = 0;
        rx_stall = 0;
        write_regs(p, 0);
        for (int i = 0; i < 20; i++)
            send_beat(random_beat(), 0, 0);
        drain();
        repeat (100) @(posedge clk);

        if (errors == 0)
            $display("grid_segment_collision_check test passed");
        else
            $display("grid_segment_collision_check test failed");
        $finish;
    end

endmodule

`default_nettype wire
